// File: rtl/sptq_pkg.sv
package sptq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_QUEUE  = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op        op;
        logic [7:0] task_tag;
        logic [7:0] task_priority;
        logic       keep;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic       head_valid;
        logic [7:0] head_tag;
        logic [7:0] head_priority;
        logic       busy_res;
        logic       busy_toggled;
    } t_res;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] pri;
    } t_entry;

endpackage

// File: rtl/sptq_ram.sv
module sptq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stable_priority_task_queue.sv
// stable priority task queue, one operation in flight, entries kept sorted in a 1r1w ram
// a new item is not taken until the current one has finished, as the single ram port pair
// walks the stored entries one by one
// busy is high from the cycle after start until the last step, but full, empty and unused ops
// finish straight from idle and never raise it; o_done pulses once per item
// and the receiver cannot stall; synchronous active-low reset empties the queue, no clearing pass
module stable_priority_task_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sptq_pkg::t_cmd i_cmd,
    output logic          o_done,
    output sptq_pkg::t_res o_res
);
    import sptq_pkg::*;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_STEP = 9'b000000010,  // look at the entry below the hole
        S_INS_CMP  = 9'b000000100,  // move it up or drop the new entry in
        S_POP_HEAD = 9'b000001000,  // read the head
        S_POP_CAP  = 9'b000010000,  // capture the head
        S_POP_STEP = 9'b000100000,  // read next entry to shift down
        S_POP_MOVE = 9'b001000000,  // write it one slot lower
        S_REM_STEP = 9'b010000000,  // read next entry to filter
        S_REM_MOVE = 9'b100000000   // keep it unless the tag matches
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;     // hole on insert, read pointer on shift/remove
    logic [CNT_W-1:0]   r_wr, n_wr;       // write pointer on remove
    logic               r_run_flag, n_run_flag;
    logic [7:0]         r_tag, n_tag;     // tag being inserted, popped or removed
    logic [7:0]         r_pri, n_pri;
    logic               r_is_pop, n_is_pop;
    logic               r_keep, n_keep;
    logic               r_done, n_done;
    t_res               r_res, n_res;

    // ram port
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_entry             w_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    t_entry             w_rdata;

    // finish of the current item
    logic               w_fin;
    t_status            w_fin_status;
    logic               w_fin_hv;
    logic               w_fin_busy;
    logic [CNT_W-1:0]   w_idx_m1;

    assign w_idx_m1 = r_idx - CNT_W'(1);

    sptq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_tag        = r_tag;
        n_pri        = r_pri;
        n_is_pop     = r_is_pop;
        n_keep       = r_keep;
        w_we         = 1'b0;
        w_waddr      = r_idx[ADDR_W-1:0];
        w_wdata      = '{tag: r_tag, pri: r_pri};
        w_raddr      = w_idx_m1[ADDR_W-1:0];
        w_fin        = 1'b0;
        w_fin_status = ST_OK;
        w_fin_hv     = 1'b0;
        w_fin_busy   = r_run_flag;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_tag    = i_cmd.task_tag;
                    n_pri    = i_cmd.task_priority;
                    n_keep   = i_cmd.keep;
                    n_is_pop = 1'b0;
                    case (i_cmd.op)
                        OP_QUEUE: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                // full: drop, nothing changes
                                w_fin        = 1'b1;
                                w_fin_status = ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_STEP;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                w_fin        = 1'b1;
                                w_fin_status = ST_EMPTY;
                                w_fin_busy   = 1'b0;
                            end else begin
                                n_is_pop = 1'b1;
                                n_state  = S_POP_HEAD;
                            end
                        end
                        OP_REMOVE: begin
                            n_idx   = '0;
                            n_wr    = '0;
                            n_state = S_REM_STEP;
                        end
                        default: begin
                            // unused op code answers ok and changes nothing
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_STEP: begin
                if (r_idx == '0) begin
                    // hole reached the head
                    w_we       = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    w_fin      = 1'b1;
                    w_fin_hv   = r_is_pop;
                    w_fin_busy = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (w_rdata.pri > r_pri) begin
                    // entry below is served later, move it up into the hole
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_idx   = w_idx_m1;
                    n_state = S_INS_STEP;
                end else begin
                    // stable: new entry goes behind its equals
                    w_we       = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                    w_fin      = 1'b1;
                    w_fin_hv   = r_is_pop;
                    w_fin_busy = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_POP_HEAD: begin
                w_raddr = '0;
                n_state = S_POP_CAP;
            end
            S_POP_CAP: begin
                n_tag   = w_rdata.tag;
                n_pri   = w_rdata.pri;
                n_idx   = CNT_W'(1);
                n_state = S_POP_STEP;
            end
            S_POP_STEP: begin
                w_raddr = r_idx[ADDR_W-1:0];
                if (r_idx == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_keep) begin
                        // reinsert the popped task from the new tail
                        n_idx   = r_count - CNT_W'(1);
                        n_state = S_INS_STEP;
                    end else begin
                        w_fin    = 1'b1;
                        w_fin_hv = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_POP_MOVE;
                end
            end
            S_POP_MOVE: begin
                w_we    = 1'b1;
                w_waddr = w_idx_m1[ADDR_W-1:0];
                w_wdata = w_rdata;
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_POP_STEP;
            end
            S_REM_STEP: begin
                w_raddr = r_idx[ADDR_W-1:0];
                if (r_idx == r_count) begin
                    w_fin        = 1'b1;
                    w_fin_status = (r_wr == r_count) ? ST_NOTFOUND : ST_OK;
                    n_count      = r_wr;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_REM_MOVE;
                end
            end
            S_REM_MOVE: begin
                if (w_rdata.tag != r_tag) begin
                    // compact survivors toward the head
                    w_we    = 1'b1;
                    w_waddr = r_wr[ADDR_W-1:0];
                    w_wdata = w_rdata;
                    n_wr    = r_wr + CNT_W'(1);
                end
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_REM_STEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_run_flag = w_fin ? w_fin_busy : r_run_flag;
        n_done     = w_fin;
        n_res      = r_res;
        if (w_fin) begin
            n_res.status        = w_fin_status;
            n_res.head_valid    = w_fin_hv;
            n_res.head_tag      = w_fin_hv ? n_tag : 8'd0;
            n_res.head_priority = w_fin_hv ? n_pri : 8'd0;
            n_res.busy_res      = w_fin_busy;
            n_res.busy_toggled  = w_fin_busy != r_run_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_run_flag <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_run_flag <= n_run_flag;
            r_done     <= n_done;
        end
    end

    // payload and work pointers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_tag    <= n_tag;
        r_pri    <= n_pri;
        r_is_pop <= n_is_pop;
        r_keep   <= n_keep;
        r_res    <= n_res;
    end

    assign busy   = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_res  = r_res;

    // store never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    // a returned head always comes with ok status
    a_head_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.head_valid |-> o_res.status == ST_OK)
        else $error("head returned with bad status");

    // reported busy matches the flag now held
    a_busy_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.busy_res == r_run_flag)
        else $error("reported busy differs from flag");

    // remove compaction never overtakes its read pointer
    a_rem_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM_STEP || r_state == S_REM_MOVE) |-> r_wr <= r_idx)
        else $error("remove write pointer ahead of read");

    // an item finishes only while the sequencer is working or taking a start
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) || $past(start))
        else $error("result without an item");

endmodule

// File: test/tb_stable_priority_task_queue.sv
`timescale 1ns / 100ps

module tb_stable_priority_task_queue;
    import sptq_pkg::*;

    localparam int STALL_LIMIT = 1000;  // cycles with no item in or result out
    localparam int DRAIN_WAIT  = 100;   // covers a keep pop on a full store
    localparam int NUM_RANDOM  = 1100;
    localparam int QUIET_TAIL  = 150;   // last items run back to back

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_cmd   i_cmd;
    logic   o_done;
    t_res   o_res;

    // queue contents and busy flag mirrored in the testbench, one result per item
    class task_queue_tracker;
        t_entry  store[QUEUE_DEPTH];
        int      count;
        bit      run_flag;
        t_res    expected_results[$];
        int      fail_count;

        function new();
            count = 0;
            run_flag = 1'b0;
            fail_count = 0;
        endfunction

        // stable insert: behind every entry of equal or smaller priority
        function bit place_entry(logic [7:0] tag, logic [7:0] pri);
            int pos;
            pos = 0;
            if (count >= QUEUE_DEPTH) return 1'b0;
            while (pos < count && store[pos].pri <= pri) pos++;
            for (int k = count; k > pos; k--) store[k] = store[k - 1];
            store[pos].tag = tag;
            store[pos].pri = pri;
            count++;
            return 1'b1;
        endfunction

        function void note_cmd(t_cmd c);
            t_res r;
            bit   old_busy;
            int   w;
            r = '0;
            r.status = ST_OK;
            old_busy = run_flag;
            case (c.op)
                OP_QUEUE: begin
                    if (place_entry(c.task_tag, c.task_priority)) run_flag = 1'b1;
                    else r.status = ST_FULL;
                end
                OP_POP: begin
                    if (count == 0) begin
                        r.status = ST_EMPTY;
                        run_flag = 1'b0;
                    end else begin
                        r.head_valid    = 1'b1;
                        r.head_tag      = store[0].tag;
                        r.head_priority = store[0].pri;
                        for (int k = 1; k < count; k++) store[k - 1] = store[k];
                        count--;
                        if (c.keep) begin
                            void'(place_entry(r.head_tag, r.head_priority));
                            run_flag = 1'b1;
                        end
                    end
                end
                OP_REMOVE: begin
                    w = 0;
                    for (int k = 0; k < count; k++) begin
                        if (store[k].tag != c.task_tag) begin
                            store[w] = store[k];
                            w++;
                        end
                    end
                    if (w == count) r.status = ST_NOTFOUND;
                    count = w;
                end
                default: ;
            endcase
            r.busy_res     = run_flag;
            r.busy_toggled = (old_busy != run_flag);
            expected_results.push_back(r);
        endfunction

        function void log_failure(string msg);
            fail_count++;
            if (fail_count <= 10) $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check_res(t_res r);
            t_res e;
            if (expected_results.size() == 0) begin
                log_failure($sformatf("result with nothing outstanding: %p", r));
                return;
            end
            e = expected_results.pop_front();
            if (r.status !== e.status || r.head_valid !== e.head_valid ||
                r.head_tag !== e.head_tag || r.head_priority !== e.head_priority ||
                r.busy_res !== e.busy_res || r.busy_toggled !== e.busy_toggled)
                log_failure($sformatf("expected %p, got %p", e, r));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    task_queue_tracker sb;
    int  stall_cycles;
    bit  gaps_on;

    stable_priority_task_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // monitor: items are taken when start is high and busy low, results on o_done
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_cmd(i_cmd);
        if (i_rst_n && o_done) sb.check_res(o_res);
    end

    // watchdog: ends a hung run
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // present one item and hold it until taken, then maybe idle for a short burst
    task automatic issue(input t_op op, input logic [7:0] tag, input logic [7:0] pri,
                         input logic keep);
        t_cmd c;
        c.op = op;
        c.task_tag = tag;
        c.task_priority = pri;
        c.keep = keep;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // mostly tags from a small pool so removes find matches, sometimes any tag
    function automatic logic [7:0] pick_tag();
        if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // priorities bunched low to make many equals, sometimes anywhere in range
    function automatic logic [7:0] pick_pri();
        if ($urandom_range(0, 99) < 50) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_item(input int mode);
        int         roll;
        int         q_pct;
        int         p_pct;
        logic [7:0] tag;
        roll = $urandom_range(0, 99);
        // fill, drain or mixed phase
        q_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
        p_pct = (mode == 0) ? 15 : (mode == 1) ? 65 : 35;
        if (roll < q_pct) begin
            issue(OP_QUEUE, pick_tag(), pick_pri(), 1'($urandom_range(0, 1)));
        end else if (roll < q_pct + p_pct) begin
            issue(OP_POP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        end else if (roll < 97) begin
            // mostly remove a tag that is stored right now
            if (sb.count > 0 && $urandom_range(0, 99) < 70)
                tag = sb.store[$urandom_range(0, sb.count - 1)].tag;
            else
                tag = pick_tag();
            issue(OP_REMOVE, tag, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            issue(OP_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int mode;
        sb = new();
        gaps_on = 1'b0;
        stall_cycles = 0;
        start <= 1'b0;
        i_cmd <= '0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, unused op, extremes, equal priorities, full store
        issue(OP_POP, 8'd0, 8'd0, 1'b0);
        issue(OP_REMOVE, 8'h55, 8'd0, 1'b0);
        issue(OP_NONE, 8'hff, 8'hff, 1'b1);
        issue(OP_QUEUE, 8'hff, 8'hff, 1'b0);
        issue(OP_QUEUE, 8'h00, 8'h00, 1'b1);
        for (int k = 1; k <= 14; k++)
            issue(OP_QUEUE, 8'(k), 8'((k % 3) * 100), 1'b0);
        issue(OP_QUEUE, 8'd200, 8'd7, 1'b0);    // store full, dropped
        issue(OP_POP, 8'd0, 8'd0, 1'b1);         // head goes back behind its equals
        issue(OP_POP, 8'd0, 8'd0, 1'b0);
        issue(OP_QUEUE, 8'd9, 8'd50, 1'b0);      // second entry with tag 9
        issue(OP_REMOVE, 8'd9, 8'd0, 1'b0);      // removes both
        issue(OP_NONE, 8'd0, 8'd0, 1'b0);

        // random part in phases that fill, drain or mix the store
        mode = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 64 == 0) mode = $urandom_range(0, 2);
            if (n % 32 == 0) gaps_on = ($urandom_range(0, 2) != 0);
            if (n >= NUM_RANDOM - QUIET_TAIL) gaps_on = 1'b0;
            if (n == NUM_RANDOM / 2) begin
                // hold off until every outstanding result is back
                start <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            random_item(mode);
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sptq_pkg.sv
rtl/sptq_ram.sv
rtl/stable_priority_task_queue.sv
test/tb_stable_priority_task_queue.sv
